// ===== sv/pid_controller_normalized_clamped_macros.svh =====
// Assertion macros used by the port-level checker of the PID controller.
`ifndef PID_CONTROLLER_NORMALIZED_CLAMPED_MACROS_SVH
`define PID_CONTROLLER_NORMALIZED_CLAMPED_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PIDNC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PIDNC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pidnc_pkg.sv =====
// Types, constants and control structs of the PID controller.
package pidnc_pkg;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [31:0] drive_t;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ERROR_SCALE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SUM_LIMIT   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OUT_MAX     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_OUT_MIN     = 3'd6;

  // 0.999 in Q1.15
  localparam int ErrSat = 32735;

  typedef struct packed {
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic [31:0]        error_scale;
    logic [30:0]        sum_limit;
    logic signed [31:0] out_max;
    logic signed [31:0] out_min;
  } cfg_t;

  typedef enum logic [1:0] {
    MUL_NORM = 2'd0,
    MUL_P    = 2'd1,
    MUL_I    = 2'd2,
    MUL_D    = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     cap_in;
    mul_sel_t mul_sel;
    logic     ld_prod;
    logic     ld_err;
    logic     acc_ld;
    logic     acc_add;
    logic     ld_out;
  } cmd_t;

endpackage

// ===== sv/pidnc_if.sv =====
// Valid/ready channel interfaces for samples and controller output.
interface pidnc_in_if;
  logic                valid;
  logic                ready;
  pidnc_pkg::sample_t  setpoint;
  pidnc_pkg::sample_t  measured;
  modport source (output valid, output setpoint, output measured, input ready);
  modport sink (input valid, input setpoint, input measured, output ready);
endinterface

interface pidnc_out_if;
  logic               valid;
  logic               ready;
  pidnc_pkg::drive_t  drive;
  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface

// ===== sv/pidnc_regs.sv =====
// Configuration register bank of the PID controller.
module pidnc_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pidnc_pkg::CfgIdxW-1:0]     cfg_idx,
  input  logic [pidnc_pkg::CfgDataW-1:0]    cfg_wdata,
  output pidnc_pkg::cfg_t                   cfg
);

  pidnc_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        pidnc_pkg::REG_GAIN_P:      cfg_nxt.gain_p      = cfg_wdata;
        pidnc_pkg::REG_GAIN_I:      cfg_nxt.gain_i      = cfg_wdata;
        pidnc_pkg::REG_GAIN_D:      cfg_nxt.gain_d      = cfg_wdata;
        pidnc_pkg::REG_ERROR_SCALE: cfg_nxt.error_scale = cfg_wdata;
        pidnc_pkg::REG_SUM_LIMIT:   cfg_nxt.sum_limit   = cfg_wdata[30:0];
        pidnc_pkg::REG_OUT_MAX:     cfg_nxt.out_max     = cfg_wdata;
        pidnc_pkg::REG_OUT_MIN:     cfg_nxt.out_min     = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p      <= '0;
      cfg_r.gain_i      <= '0;
      cfg_r.gain_d      <= '0;
      cfg_r.error_scale <= 32'h8000_0000;
      cfg_r.sum_limit   <= 31'h7FFF_FFFF;
      cfg_r.out_max     <= 32'sd32767;
      cfg_r.out_min     <= -32'sd32768;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/pidnc_ctrl.sv =====
// Sequencing state machine of the PID controller.
module pidnc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pidnc_pkg::cmd_t   cmd
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_NORM = 8'b0000_0010,
    ST_ERR  = 8'b0000_0100,
    ST_MULP = 8'b0000_1000,
    ST_MULI = 8'b0001_0000,
    ST_MULD = 8'b0010_0000,
    ST_ACCD = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = pidnc_pkg::MUL_NORM;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = ST_NORM;
        end
      end
      ST_NORM: begin
        cmd.mul_sel = pidnc_pkg::MUL_NORM;
        cmd.ld_prod = 1'b1;
        state_nxt   = ST_ERR;
      end
      ST_ERR: begin
        cmd.ld_err = 1'b1;
        state_nxt  = ST_MULP;
      end
      ST_MULP: begin
        cmd.mul_sel = pidnc_pkg::MUL_P;
        cmd.ld_prod = 1'b1;
        state_nxt   = ST_MULI;
      end
      ST_MULI: begin
        cmd.mul_sel = pidnc_pkg::MUL_I;
        cmd.ld_prod = 1'b1;
        cmd.acc_ld  = 1'b1;
        state_nxt   = ST_MULD;
      end
      ST_MULD: begin
        cmd.mul_sel = pidnc_pkg::MUL_D;
        cmd.ld_prod = 1'b1;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_ACCD;
      end
      ST_ACCD: begin
        cmd.acc_add = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/pidnc_dp.sv =====
// Datapath of the PID controller: shared multiplier, error state, accumulator.
module pidnc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  pidnc_pkg::cmd_t     cmd,
  input  pidnc_pkg::cfg_t     cfg,
  input  pidnc_pkg::sample_t  setpoint,
  input  pidnc_pkg::sample_t  measured,
  output pidnc_pkg::drive_t   drive
);

  logic signed [16:0] diff_r;
  logic signed [65:0] prod_r;
  logic signed [65:0] acc_r;
  logic signed [15:0] e_r;
  logic signed [31:0] s_r;
  logic signed [16:0] de_r;
  logic signed [15:0] prev_error_r;
  logic signed [31:0] error_sum_r;
  logic signed [31:0] drive_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  logic signed [49:0] sh_c;
  logic signed [15:0] e_c;
  logic signed [32:0] sum_c, lim_c;
  logic signed [31:0] s_c;
  logic signed [16:0] de_c;

  logic signed [49:0] y_c, y_hi_c, y_c2, omax_c, omin_c;

  always_comb begin
    case (cmd.mul_sel)
      pidnc_pkg::MUL_NORM: begin
        mul_a = 33'(diff_r);
        mul_b = $signed({1'b0, cfg.error_scale});
      end
      pidnc_pkg::MUL_P: begin
        mul_a = 33'(cfg.gain_p);
        mul_b = 33'(e_r);
      end
      pidnc_pkg::MUL_I: begin
        mul_a = 33'(cfg.gain_i);
        mul_b = 33'(s_r);
      end
      pidnc_pkg::MUL_D: begin
        mul_a = 33'(cfg.gain_d);
        mul_b = 33'(de_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    sh_c = prod_r[65:16];
    if (sh_c > 50'(pidnc_pkg::ErrSat)) begin
      e_c = 16'(pidnc_pkg::ErrSat);
    end else if (sh_c < 50'(-pidnc_pkg::ErrSat)) begin
      e_c = 16'(-pidnc_pkg::ErrSat);
    end else begin
      e_c = sh_c[15:0];
    end
    sum_c = 33'(error_sum_r) + 33'(e_c);
    lim_c = $signed({2'b00, cfg.sum_limit});
    if (sum_c > lim_c) begin
      s_c = lim_c[31:0];
    end else if (sum_c < -lim_c) begin
      s_c = 32'(-lim_c);
    end else begin
      s_c = sum_c[31:0];
    end
    de_c = 17'(e_c) - 17'(prev_error_r);
  end

  always_comb begin
    y_c    = acc_r[65:16];
    omax_c = 50'(cfg.out_max);
    omin_c = 50'(cfg.out_min);
    y_hi_c = (y_c > omax_c) ? omax_c : y_c;
    y_c2   = (y_hi_c < omin_c) ? omin_c : y_hi_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r <= '0;
      error_sum_r  <= '0;
    end else if (cmd.ld_err) begin
      prev_error_r <= e_c;
      error_sum_r  <= s_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      diff_r <= 17'(setpoint) - 17'(measured);
    end
    if (cmd.ld_prod) begin
      prod_r <= mul_p;
    end
    if (cmd.ld_err) begin
      e_r  <= e_c;
      s_r  <= s_c;
      de_r <= de_c;
    end
    if (cmd.acc_ld) begin
      acc_r <= prod_r;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + prod_r;
    end
    if (cmd.ld_out) begin
      drive_r <= y_c2[31:0];
    end
  end

  assign drive = drive_r;

endmodule

// ===== sv/pid_controller_normalized_clamped.sv =====
// PID controller with normalized error and clamped integrator and output.
// Each transaction steps through the states NORM, ERR, MULP, MULI, MULD, ACCD and
// DONE from acceptance to a result in the output register, DONE waiting while the
// output channel stalls a previous result: one 33x33 signed multiplier is shared
// for the normalization and the three gain products, each result registered
// before it is accumulated. A new sample is accepted only once the previous
// result has moved to the output register.
module pid_controller_normalized_clamped (
  input  logic                             clk,
  input  logic                             rst_n,
  pidnc_in_if.sink                         in_ch,
  pidnc_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [pidnc_pkg::CfgIdxW-1:0]    cfg_idx,
  input  logic [pidnc_pkg::CfgDataW-1:0]   cfg_wdata
);

  pidnc_pkg::cfg_t cfg;
  pidnc_pkg::cmd_t cmd;

  pidnc_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pidnc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  pidnc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg),
    .setpoint (in_ch.setpoint),
    .measured (in_ch.measured),
    .drive    (out_ch.drive)
  );

endmodule

// ===== sv/pidnc_checker.sv =====
// Port-level checker of the PID controller and its bind.
`include "pid_controller_normalized_clamped_macros.svh"

module pidnc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  `PIDNC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "output transaction dropped while stalled")
  `PIDNC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "input accepted while still busy")
  `PIDNC_ASSERT_SAME(a_no_instant_result, clk, rst_n, $rose(out_valid), !$past(in_valid && in_ready), "result appeared one cycle after acceptance")
  `PIDNC_ASSERT_NEXT(a_busy_two, clk, rst_n, in_valid && in_ready, ##1 !in_ready, "input accepted during computation")

endmodule

bind pid_controller_normalized_clamped pidnc_checker u_pidnc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the normalized, clamped PID controller.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [pidnc_pkg::CfgIdxW-1:0] REG_NONE = 3'd7;
  localparam int StallLimit = 3000;
  localparam int DrainCycles = 16;
  localparam int RandPhases = 8;
  localparam int PhaseItems = 185;

  typedef struct {
    pidnc_pkg::sample_t sp;
    pidnc_pkg::sample_t ms;
  } sample_pair_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [pidnc_pkg::CfgIdxW-1:0] cfg_idx;
  logic [pidnc_pkg::CfgDataW-1:0] cfg_wdata;

  pidnc_in_if in_ch ();
  pidnc_out_if out_ch ();

  pid_controller_normalized_clamped dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // controller copy: gains, limits and loop state
  longint m_gp, m_gi, m_gd, m_scale, m_lim, m_omax, m_omin;
  longint m_prev, m_sum;

  sample_pair_t pend_q[$];
  pidnc_pkg::drive_t drive_q[$];
  pidnc_pkg::drive_t exp_drive;
  int n_sent, n_taken, n_results, errs, idle_cycles;
  logic in_fire;

  // sender burst state
  int burst_left, gap_left;
  sample_pair_t cur;

  // receiver stall state
  rx_mode_t rx_mode;
  int mode_left, hold_left, rx_cnt;
  logic long_hold_done;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic pidnc_pkg::drive_t next_drive(input pidnc_pkg::sample_t sp,
                                                   input pidnc_pkg::sample_t ms);
    longint diff, e, s, de, acc, y;
    diff = longint'(sp) - longint'(ms);
    e = (diff * m_scale) >>> 16;
    if (e > pidnc_pkg::ErrSat) e = pidnc_pkg::ErrSat;
    if (e < -pidnc_pkg::ErrSat) e = -pidnc_pkg::ErrSat;
    s = m_sum + e;
    if (s > m_lim) s = m_lim;
    if (s < -m_lim) s = -m_lim;
    m_sum = s;
    de = e - m_prev;
    m_prev = e;
    acc = m_gp * e + m_gi * s + m_gd * de;
    y = acc >>> 16;
    if (y > m_omax) y = m_omax;
    if (y < m_omin) y = m_omin;
    return pidnc_pkg::drive_t'(y[31:0]);
  endfunction

  task automatic write_reg(input logic [pidnc_pkg::CfgIdxW-1:0] idx,
                           input logic [pidnc_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      pidnc_pkg::REG_GAIN_P:      m_gp = longint'(signed'(val));
      pidnc_pkg::REG_GAIN_I:      m_gi = longint'(signed'(val));
      pidnc_pkg::REG_GAIN_D:      m_gd = longint'(signed'(val));
      pidnc_pkg::REG_ERROR_SCALE: m_scale = longint'(val);
      pidnc_pkg::REG_SUM_LIMIT:   m_lim = longint'(val[30:0]);
      pidnc_pkg::REG_OUT_MAX:     m_omax = longint'(signed'(val));
      pidnc_pkg::REG_OUT_MIN:     m_omin = longint'(signed'(val));
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_pair(input pidnc_pkg::sample_t sp, input pidnc_pkg::sample_t ms);
    sample_pair_t p;
    p.sp = sp;
    p.ms = ms;
    pend_q.push_back(p);
    n_sent++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (!(n_taken == n_sent && drive_q.size() == 0));
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      3: return 32'h0;
      default: return $urandom_range(0, 32'h6_0000) - 32'h3_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return $urandom;
      default: return $urandom_range(32'h1000, 32'h8000_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(1, 200000);
    endcase
  endfunction

  task automatic random_config();
    logic [31:0] hi, lo, w;
    case ($urandom_range(0, 3))
      0: begin
        hi = 32'h7FFF_FFFF;
        lo = 32'h8000_0000;
      end
      1: begin
        hi = 32'h0000_7FFF;
        lo = 32'hFFFF_8000;
      end
      2: begin
        hi = $urandom;
        lo = $urandom;
      end
      default: begin
        w = $urandom_range(0, 5000);
        hi = w;
        lo = -w;
      end
    endcase
    write_reg(pidnc_pkg::REG_GAIN_P, pick_gain());
    write_reg(pidnc_pkg::REG_GAIN_I, pick_gain());
    write_reg(pidnc_pkg::REG_GAIN_D, pick_gain());
    write_reg(pidnc_pkg::REG_ERROR_SCALE, pick_scale());
    write_reg(pidnc_pkg::REG_SUM_LIMIT, pick_limit());
    write_reg(pidnc_pkg::REG_OUT_MAX, hi);
    write_reg(pidnc_pkg::REG_OUT_MIN, lo);
    if ($urandom_range(0, 2) == 0) write_reg(REG_NONE, $urandom);
    end_writes();
  endtask

  task automatic random_items(input int n);
    pidnc_pkg::sample_t sp, ms;
    int off;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          sp = pidnc_pkg::sample_t'($urandom);
          ms = pidnc_pkg::sample_t'($urandom);
        end
        2: begin
          ms = pidnc_pkg::sample_t'($urandom);
          off = int'($urandom_range(0, 600)) - 300;
          sp = pidnc_pkg::sample_t'(int'(ms) + off);
        end
        default: begin
          sp = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
          ms = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
        end
      endcase
      add_pair(sp, ms);
    end
  endtask

  // sender: bursts and gaps, holds the item until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fire) begin
    end else if (gap_left > 0) begin
      gap_left--;
      in_ch.valid <= 1'b0;
    end else if (pend_q.size() > 0) begin
      cur = pend_q.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.setpoint <= cur.sp;
      in_ch.measured <= cur.ms;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // receiver: stall pattern plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (!long_hold_done && n_results >= 120) begin
        hold_left = 400;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 300);
        end
        mode_left--;
        rx_cnt++;
        case (rx_mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ch.ready <= (rx_cnt % 4 == 0);
          default:   out_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // monitor, predictor hook and watchdog
  always @(posedge clk) begin
    in_fire = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (drive_q.size() == 0) begin
          $error("drive: no transaction expected, got %0d", out_ch.drive);
          errs++;
        end else begin
          exp_drive = drive_q.pop_front();
          if (out_ch.drive !== exp_drive) begin
            $error("drive mismatch: expected %0d, got %0d", exp_drive, out_ch.drive);
            errs++;
          end
        end
      end
      in_fire = in_ch.valid && in_ch.ready;
      if (in_fire) begin
        drive_q.push_back(next_drive(in_ch.setpoint, in_ch.measured));
        n_taken++;
      end
      if (in_fire || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.setpoint = '0;
    in_ch.measured = '0;
    out_ch.ready = 1'b0;
    m_gp = 0;
    m_gi = 0;
    m_gd = 0;
    m_scale = 64'h8000_0000;
    m_lim = 64'h7FFF_FFFF;
    m_omax = 32767;
    m_omin = -32768;
    m_prev = 0;
    m_sum = 0;
    n_sent = 0;
    n_taken = 0;
    n_results = 0;
    errs = 0;
    idle_cycles = 0;
    in_fire = 1'b0;
    burst_left = 0;
    gap_left = 0;
    mode_left = 0;
    hold_left = 0;
    rx_cnt = 0;
    rx_mode = RX_OPEN;
    long_hold_done = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values
    add_pair(16'sd100, -16'sd100);
    add_pair(16'sh7FFF, 16'sh8000);
    add_pair(16'sh8000, 16'sh7FFF);
    add_pair(16'sd0, 16'sd0);
    wait_idle();

    // full-scale error, both signs, integrator up to its limit
    write_reg(pidnc_pkg::REG_GAIN_P, 32'h0001_0000);
    write_reg(pidnc_pkg::REG_GAIN_I, 32'h0000_4000);
    write_reg(pidnc_pkg::REG_GAIN_D, 32'hFFFF_8000);
    write_reg(pidnc_pkg::REG_ERROR_SCALE, 32'h8000_0000);
    write_reg(pidnc_pkg::REG_SUM_LIMIT, 32'd100000);
    write_reg(pidnc_pkg::REG_OUT_MAX, 32'h7FFF_FFFF);
    write_reg(pidnc_pkg::REG_OUT_MIN, 32'h8000_0000);
    end_writes();
    add_pair(16'sd0, 16'sd0);
    add_pair(16'sh7FFF, 16'sh8000);
    add_pair(16'sh8000, 16'sh7FFF);
    add_pair(16'sd1, 16'sd0);
    add_pair(16'sd0, 16'sd1);
    add_pair(-16'sd1, -16'sd1);
    add_pair(16'sd100, 16'sd50);
    add_pair(16'sh7FFF, 16'sh7FFF);
    add_pair(16'sh8000, 16'sh8000);
    repeat (6) add_pair(16'sh7FFF, 16'sh8000);
    wait_idle();

    // lowered sum limit below the accumulator, scale above 2^31,
    // crossed output limits, extreme gains, unmapped index
    write_reg(pidnc_pkg::REG_SUM_LIMIT, 32'd1000);
    write_reg(pidnc_pkg::REG_ERROR_SCALE, 32'hFFFF_FFFF);
    write_reg(pidnc_pkg::REG_GAIN_P, 32'h7FFF_FFFF);
    write_reg(pidnc_pkg::REG_GAIN_I, 32'h8000_0000);
    write_reg(pidnc_pkg::REG_GAIN_D, 32'h7FFF_FFFF);
    write_reg(pidnc_pkg::REG_OUT_MAX, -32'sd100);
    write_reg(pidnc_pkg::REG_OUT_MIN, 32'sd100);
    write_reg(REG_NONE, 32'hDEAD_BEEF);
    end_writes();
    add_pair(16'sd5, 16'sd0);
    add_pair(-16'sd5, 16'sd0);
    add_pair(16'sh7FFF, 16'sh8000);
    add_pair(16'sd0, 16'sd0);
    add_pair(16'sh8000, 16'sh7FFF);
    wait_idle();

    // tiny scale, sum limit written with bit 31 set
    write_reg(pidnc_pkg::REG_ERROR_SCALE, 32'h0000_0001);
    write_reg(pidnc_pkg::REG_SUM_LIMIT, 32'hFFFF_FFFF);
    write_reg(pidnc_pkg::REG_GAIN_P, 32'h0002_0000);
    write_reg(pidnc_pkg::REG_OUT_MAX, 32'h0000_7FFF);
    write_reg(pidnc_pkg::REG_OUT_MIN, 32'hFFFF_8000);
    end_writes();
    add_pair(16'sh7FFF, 16'sh8000);
    add_pair(16'sh8000, 16'sh7FFF);
    add_pair(16'sd1, 16'sd0);
    add_pair(16'sd0, 16'sd1);
    wait_idle();

    repeat (RandPhases) begin
      random_config();
      random_items(PhaseItems);
      wait_idle();
    end

    if (errs == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
